@@ hw/rtl/gca_pkg.sv @@
// Shared constants, types and step functions for the great-circle arc length pipeline.
package gca_pkg;

   // angle format and iteration counts
   localparam int ANG_BITS     = 30;
   localparam int RSQ_STEPS    = 34;
   localparam int DIV_STEPS    = 30;
   localparam int SIN_STEPS    = 31;
   localparam int CORDIC_STEPS = 30;

   localparam logic [31:0] PI_Q30 = 32'd3373259426;

   // register indexes on the configuration port
   localparam logic [1:0] REG_CENTER_X = 2'd0;
   localparam logic [1:0] REG_CENTER_Y = 2'd1;
   localparam logic [1:0] REG_CENTER_Z = 2'd2;
   localparam int         REG_COUNT    = 3;

   // flags that travel with an item
   typedef struct packed {
      logic zero;
      logic cneg;
      logic clamp;
   } flag_type;

   // partial state of a digit-by-digit square root
   typedef struct packed {
      logic [67:0] rem;
      logic [67:0] res;
   } sqrt_type;

   // one step of the restoring square root, one = current power of four
   function automatic sqrt_type sqrt_step(sqrt_type cur, logic [67:0] one);
      sqrt_type   nxt;
      logic [67:0] trial;
      trial = cur.res + one;
      if (cur.rem >= trial) begin
         nxt.rem = cur.rem - trial;
         nxt.res = (cur.res >> 1) + one;
      end else begin
         nxt.rem = cur.rem;
         nxt.res = cur.res >> 1;
      end
      return nxt;
   endfunction

   // arctangent of 2^-i in Q30, rounded to nearest
   function automatic logic signed [33:0] atan_val(int i);
      logic signed [33:0] v;
      v = '0;
      case (i)
         0:       v = 34'sd843314857;
         1:       v = 34'sd497837829;
         2:       v = 34'sd263043837;
         3:       v = 34'sd133525159;
         4:       v = 34'sd67021688;
         5:       v = 34'sd33543516;
         6:       v = 34'sd16775851;
         7:       v = 34'sd8388437;
         8:       v = 34'sd4194283;
         9:       v = 34'sd2097149;
         default: v = 34'sd1 <<< (ANG_BITS - i);
      endcase
      return v;
   endfunction

endpackage

@@ hw/rtl/gca_if.sv @@
// Valid/ready channel interfaces for point pairs and arc length results.
interface gca_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] point_a_x;
   logic signed [31:0] point_a_y;
   logic signed [31:0] point_a_z;
   logic signed [31:0] point_b_x;
   logic signed [31:0] point_b_y;
   logic signed [31:0] point_b_z;

   modport source (output valid, point_a_x, point_a_y, point_a_z,
                   point_b_x, point_b_y, point_b_z, input ready);
   modport sink   (input valid, point_a_x, point_a_y, point_a_z,
                   point_b_x, point_b_y, point_b_z, output ready);
endinterface

interface gca_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] arc_length;
   logic        zero_radius;

   modport source (output valid, arc_length, zero_radius, input ready);
   modport sink   (input valid, arc_length, zero_radius, output ready);
endinterface

@@ hw/rtl/great_circle_arc_length.sv @@
// Great-circle arc length: a fully pipelined unit that takes one point pair per clock while its
// output is not stalled. It has 136 register stages; the depth is set by the bit-per-stage square
// roots (34 and 31 stages), the 30-stage restoring divider for the cosine and the 30-stage CORDIC
// arc cosine. The whole pipeline holds while the result at its end waits, so back pressure
// also pauses intake. Centre registers sit on the APB port and should be written while no item
// is in flight.
module great_circle_arc_length (
   input  logic              clock,
   input  logic              reset,
   gca_req_if.sink           req_ch,
   gca_rsp_if.source         rsp_ch,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [3:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import gca_pkg::*;

   // stage positions
   localparam int S_R   = 5;
   localparam int S_D   = S_R + RSQ_STEPS;
   localparam int S_CM  = S_D + DIV_STEPS;
   localparam int S_CSQ = S_CM + 1;
   localparam int S_V   = S_CSQ + 1;
   localparam int S_S   = S_V + 1;
   localparam int S_C   = S_S + SIN_STEPS;
   localparam int S_TH  = S_C + CORDIC_STEPS;
   localparam int S_M   = S_TH + 1;
   localparam int DEPTH = S_M + 2;

   logic               adv;
   logic [DEPTH-1:0]   vld_ff;
   logic signed [31:0] center_ff [3];
   logic [1:0]         widx;

   // configuration port
   assign pready = 1'b1;
   assign widx   = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff[0] <= '0;
         center_ff[1] <= '0;
         center_ff[2] <= '0;
      end else if (psel && penable && pwrite) begin
         case (widx)
            REG_CENTER_X: center_ff[0] <= pwdata;
            REG_CENTER_Y: center_ff[1] <= pwdata;
            REG_CENTER_Z: center_ff[2] <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (widx)
         REG_CENTER_X: prdata = center_ff[0];
         REG_CENTER_Y: prdata = center_ff[1];
         REG_CENTER_Z: prdata = center_ff[2];
         default:      prdata = '0;
      endcase
   end

   // global advance; valid bits shift with the data
   assign adv          = !vld_ff[DEPTH-1] || rsp_ch.ready;
   assign req_ch.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[DEPTH-2:0], req_ch.valid};
      end
   end

   // stage 0: centre both points
   logic signed [31:0] pa [3];
   logic signed [31:0] pb [3];
   logic signed [32:0] da_ff [3];
   logic signed [32:0] db_ff [3];

   assign pa[0] = req_ch.point_a_x;
   assign pa[1] = req_ch.point_a_y;
   assign pa[2] = req_ch.point_a_z;
   assign pb[0] = req_ch.point_b_x;
   assign pb[1] = req_ch.point_b_y;
   assign pb[2] = req_ch.point_b_z;

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            da_ff[k] <= 33'(pa[k]) - 33'(center_ff[k]);
            db_ff[k] <= 33'(pb[k]) - 33'(center_ff[k]);
         end
      end
   end

   // stage 1: magnitudes and products
   logic [31:0] ma [3];
   logic [31:0] mb [3];
   logic [63:0] sq_ff [3];
   logic [63:0] dp_ff [3];
   logic [2:0]  ng_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         ma[k] = da_ff[k][32] ? 32'(-da_ff[k]) : da_ff[k][31:0];
         mb[k] = db_ff[k][32] ? 32'(-db_ff[k]) : db_ff[k][31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 3; k++) begin
            sq_ff[k] <= ma[k] * ma[k];
            dp_ff[k] <= ma[k] * mb[k];
            ng_ff[k] <= da_ff[k][32] ^ db_ff[k][32];
         end
      end
   end

   // stage 2: radius squared and split dot product
   logic [65:0] rsq2_ff, pos_ff, neg_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         rsq2_ff <= 66'(sq_ff[0]) + 66'(sq_ff[1]) + 66'(sq_ff[2]);
         pos_ff  <= (ng_ff[0] ? 66'd0 : 66'(dp_ff[0])) + (ng_ff[1] ? 66'd0 : 66'(dp_ff[1]))
                  + (ng_ff[2] ? 66'd0 : 66'(dp_ff[2]));
         neg_ff  <= (ng_ff[0] ? 66'(dp_ff[0]) : 66'd0) + (ng_ff[1] ? 66'(dp_ff[1]) : 66'd0)
                  + (ng_ff[2] ? 66'(dp_ff[2]) : 66'd0);
      end
   end

   // stage 3: dot magnitude and sign
   logic [65:0] rsq3_ff, dmag3_ff;
   flag_type    flg3_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         rsq3_ff       <= rsq2_ff;
         flg3_ff.zero  <= (rsq2_ff == '0);
         flg3_ff.clamp <= 1'b0;
         if (pos_ff >= neg_ff) begin
            dmag3_ff     <= pos_ff - neg_ff;
            flg3_ff.cneg <= 1'b0;
         end else begin
            dmag3_ff     <= neg_ff - pos_ff;
            flg3_ff.cneg <= 1'b1;
         end
      end
   end

   // stage 4: cosine clamp
   logic [65:0] rsq4_ff, dmag4_ff;
   flag_type    flg4_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         rsq4_ff       <= rsq3_ff;
         dmag4_ff      <= dmag3_ff;
         flg4_ff.zero  <= flg3_ff.zero;
         flg4_ff.cneg  <= flg3_ff.cneg;
         flg4_ff.clamp <= (dmag3_ff >= rsq3_ff);
      end
   end

   // radius: square root of r^2, one bit per stage
   sqrt_type    rr_ff     [RSQ_STEPS];
   logic [65:0] r_rsq_ff  [RSQ_STEPS];
   logic [65:0] r_dmag_ff [RSQ_STEPS];
   flag_type    r_flg_ff  [RSQ_STEPS];

   for (genvar j = 0; j < RSQ_STEPS; j++) begin : g_rsq
      sqrt_type    src;
      logic [65:0] src_rsq, src_dmag;
      flag_type    src_flg;
      if (j == 0) begin : g_first
         assign src.rem  = 68'(rsq4_ff);
         assign src.res  = '0;
         assign src_rsq  = rsq4_ff;
         assign src_dmag = dmag4_ff;
         assign src_flg  = flg4_ff;
      end else begin : g_next
         assign src      = rr_ff[j-1];
         assign src_rsq  = r_rsq_ff[j-1];
         assign src_dmag = r_dmag_ff[j-1];
         assign src_flg  = r_flg_ff[j-1];
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            rr_ff[j]     <= sqrt_step(src, 68'd1 << (2 * (RSQ_STEPS - 1 - j)));
            r_rsq_ff[j]  <= src_rsq;
            r_dmag_ff[j] <= src_dmag;
            r_flg_ff[j]  <= src_flg;
         end
      end
   end

   // cosine magnitude: restoring divide dmag / r^2, one quotient bit per stage
   logic [66:0] dv_rem_ff [DIV_STEPS];
   logic [29:0] dv_q_ff   [DIV_STEPS];
   logic [65:0] dv_rsq_ff [DIV_STEPS];
   logic [33:0] dv_r_ff   [DIV_STEPS];
   flag_type    dv_flg_ff [DIV_STEPS];

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      logic [66:0] src_rem, sh;
      logic [29:0] src_q;
      logic [65:0] src_rsq;
      logic [33:0] src_r;
      flag_type    src_flg;
      if (j == 0) begin : g_first
         assign src_rem = 67'(r_dmag_ff[RSQ_STEPS-1]);
         assign src_q   = '0;
         assign src_rsq = r_rsq_ff[RSQ_STEPS-1];
         assign src_r   = rr_ff[RSQ_STEPS-1].res[33:0];
         assign src_flg = r_flg_ff[RSQ_STEPS-1];
      end else begin : g_next
         assign src_rem = dv_rem_ff[j-1];
         assign src_q   = dv_q_ff[j-1];
         assign src_rsq = dv_rsq_ff[j-1];
         assign src_r   = dv_r_ff[j-1];
         assign src_flg = dv_flg_ff[j-1];
      end
      assign sh = {src_rem[65:0], 1'b0};
      always_ff @(posedge clock) begin
         if (adv) begin
            if (sh >= 67'(src_rsq)) begin
               dv_rem_ff[j] <= sh - 67'(src_rsq);
               dv_q_ff[j]   <= {src_q[28:0], 1'b1};
            end else begin
               dv_rem_ff[j] <= sh;
               dv_q_ff[j]   <= {src_q[28:0], 1'b0};
            end
            dv_rsq_ff[j] <= src_rsq;
            dv_r_ff[j]   <= src_r;
            dv_flg_ff[j] <= src_flg;
         end
      end
   end

   // clamped cosine, its square, then 1 - c^2
   logic [30:0] cm_ff, csq_cm_ff, v_cm_ff;
   logic [60:0] csq_ff, v_ff;
   logic [33:0] cm_r_ff, csq_r_ff, v_r_ff;
   flag_type    cm_flg_ff, csq_flg_ff, v_flg_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         cm_ff      <= dv_flg_ff[DIV_STEPS-1].clamp ? (31'd1 << ANG_BITS)
                                                    : 31'(dv_q_ff[DIV_STEPS-1]);
         cm_r_ff    <= dv_r_ff[DIV_STEPS-1];
         cm_flg_ff  <= dv_flg_ff[DIV_STEPS-1];
         csq_ff     <= 61'(cm_ff * cm_ff);
         csq_cm_ff  <= cm_ff;
         csq_r_ff   <= cm_r_ff;
         csq_flg_ff <= cm_flg_ff;
         v_ff       <= (61'd1 << (2 * ANG_BITS)) - csq_ff;
         v_cm_ff    <= csq_cm_ff;
         v_r_ff     <= csq_r_ff;
         v_flg_ff   <= csq_flg_ff;
      end
   end

   // sine: square root of 1 - c^2, one bit per stage
   logic [61:0] ss_rem_ff [SIN_STEPS];
   logic [61:0] ss_res_ff [SIN_STEPS];
   logic [30:0] s_cm_ff   [SIN_STEPS];
   logic [33:0] s_r_ff    [SIN_STEPS];
   flag_type    s_flg_ff  [SIN_STEPS];

   for (genvar j = 0; j < SIN_STEPS; j++) begin : g_sin
      sqrt_type    src, nxt;
      logic [30:0] src_cm;
      logic [33:0] src_r;
      flag_type    src_flg;
      if (j == 0) begin : g_first
         assign src.rem = 68'(v_ff);
         assign src.res = '0;
         assign src_cm  = v_cm_ff;
         assign src_r   = v_r_ff;
         assign src_flg = v_flg_ff;
      end else begin : g_next
         assign src.rem = 68'(ss_rem_ff[j-1]);
         assign src.res = 68'(ss_res_ff[j-1]);
         assign src_cm  = s_cm_ff[j-1];
         assign src_r   = s_r_ff[j-1];
         assign src_flg = s_flg_ff[j-1];
      end
      assign nxt = sqrt_step(src, 68'd1 << (2 * (SIN_STEPS - 1 - j)));
      always_ff @(posedge clock) begin
         if (adv) begin
            ss_rem_ff[j] <= nxt.rem[61:0];
            ss_res_ff[j] <= nxt.res[61:0];
            s_cm_ff[j]   <= src_cm;
            s_r_ff[j]    <= src_r;
            s_flg_ff[j]  <= src_flg;
         end
      end
   end

   // angle: CORDIC vectoring of (|c|, s), one rotation per stage
   logic signed [33:0] cx_ff [CORDIC_STEPS];
   logic signed [33:0] cy_ff [CORDIC_STEPS];
   logic signed [33:0] cz_ff [CORDIC_STEPS];
   logic [33:0]        c_r_ff   [CORDIC_STEPS];
   flag_type           c_flg_ff [CORDIC_STEPS];

   for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_cordic
      logic signed [33:0] x, y, z, xs, ys;
      logic [33:0]        src_r;
      flag_type           src_flg;
      if (j == 0) begin : g_first
         assign x       = $signed({3'b000, s_cm_ff[SIN_STEPS-1]});
         assign y       = $signed({3'b000, ss_res_ff[SIN_STEPS-1][30:0]});
         assign z       = '0;
         assign src_r   = s_r_ff[SIN_STEPS-1];
         assign src_flg = s_flg_ff[SIN_STEPS-1];
      end else begin : g_next
         assign x       = cx_ff[j-1];
         assign y       = cy_ff[j-1];
         assign z       = cz_ff[j-1];
         assign src_r   = c_r_ff[j-1];
         assign src_flg = c_flg_ff[j-1];
      end
      assign xs = x >>> j;
      assign ys = y >>> j;
      always_ff @(posedge clock) begin
         if (adv) begin
            if (!y[33] && (y != '0)) begin
               cx_ff[j] <= x + ys;
               cy_ff[j] <= y - xs;
               cz_ff[j] <= z + atan_val(j);
            end else if (y[33]) begin
               cx_ff[j] <= x - ys;
               cy_ff[j] <= y + xs;
               cz_ff[j] <= z - atan_val(j);
            end else begin
               cx_ff[j] <= x;
               cy_ff[j] <= y;
               cz_ff[j] <= z;
            end
            c_r_ff[j]   <= src_r;
            c_flg_ff[j] <= src_flg;
         end
      end
   end

   // fold the angle for a negative cosine and clamp to [0, pi]
   logic signed [34:0] zz, pi_s;
   logic [31:0]        th_ff;
   logic [33:0]        th_r_ff;
   logic               th_zero_ff;

   assign pi_s = $signed({3'b000, PI_Q30});
   assign zz   = c_flg_ff[CORDIC_STEPS-1].cneg ? pi_s - 35'(cz_ff[CORDIC_STEPS-1])
                                               : 35'(cz_ff[CORDIC_STEPS-1]);

   always_ff @(posedge clock) begin
      if (adv) begin
         if (zz[34])           th_ff <= '0;
         else if (zz > pi_s)   th_ff <= PI_Q30;
         else                  th_ff <= zz[31:0];
         th_r_ff    <= c_r_ff[CORDIC_STEPS-1];
         th_zero_ff <= c_flg_ff[CORDIC_STEPS-1].zero;
      end
   end

   // r * angle as two partial products
   logic [63:0] pm_ff;
   logic [33:0] ph_ff;
   logic        m_zero_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         pm_ff     <= th_r_ff[31:0] * th_ff;
         ph_ff     <= 34'(th_r_ff[33:32] * th_ff);
         m_zero_ff <= th_zero_ff;
      end
   end

   // round, saturate and drive the output register
   logic [66:0] prod;
   logic [31:0] arc_ff;
   logic        zr_ff;

   assign prod = 67'(pm_ff) + (67'(ph_ff) << 32) + (67'd1 << (ANG_BITS - 1));

   always_ff @(posedge clock) begin
      if (adv) begin
         if (m_zero_ff)               arc_ff <= '0;
         else if (|prod[66:62])       arc_ff <= '1;
         else                         arc_ff <= prod[61:30];
         zr_ff <= m_zero_ff;
      end
   end

   assign rsp_ch.valid       = vld_ff[DEPTH-1];
   assign rsp_ch.arc_length  = arc_ff;
   assign rsp_ch.zero_radius = zr_ff;

`ifndef SYNTH
   // a zero radius always reports a zero length
   a_zero_len: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.zero_radius |-> rsp_ch.arc_length == '0)
      else $error("zero radius with nonzero arc length");

   // a held pipeline keeps every valid bit
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("pipeline valid bits moved while held");

   // the folded angle never exceeds pi
   a_theta: assert property (@(posedge clock) disable iff (reset)
      vld_ff[S_TH] |-> th_ff <= PI_Q30)
      else $error("angle above pi");

   // the cosine magnitude never exceeds one
   a_cos: assert property (@(posedge clock) disable iff (reset)
      vld_ff[S_CM] |-> cm_ff <= (31'd1 << ANG_BITS))
      else $error("cosine magnitude above one");
`endif

endmodule

@@ verif/great_circle_arc_length_test.sv @@
// Self-checking testbench for the great-circle arc length unit: predicted versus actual results.
`timescale 1ns / 100ps

module great_circle_arc_length_test;
   import gca_pkg::*;

   typedef struct {
      logic signed [31:0] ax, ay, az, bx, by, bz;
   } point_pair_type;

   typedef struct {
      logic [31:0] arc;
      logic        zero;
   } arc_result_type;

   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 160;

   logic clock;
   logic reset;
   logic psel, penable, pwrite;
   logic [3:0] paddr;
   logic [31:0] pwdata, prdata;
   logic pready;

   gca_req_if req ();
   gca_rsp_if rsp ();

   great_circle_arc_length dut (
      .clock(clock), .reset(reset), .req_ch(req.sink), .rsp_ch(rsp.source),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // predictor's copy of the centre registers
   logic signed [31:0] centre [3];
   arc_result_type pending_arcs [$];
   int  error_count;
   bit  no_idle;
   bit  hold_request;
   bit  hold_active;

   // arctangent of 2^-i, Q30, for the first ten micro-rotations
   localparam longint ATAN_Q30 [10] = '{843314857, 497837829, 263043837, 133525159,
      67021688, 33543516, 16775851, 8388437, 4194283, 2097149};

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // run limit
   initial begin
      #20_000_000;
      $display("great_circle_arc_length verification failed");
      $finish;
   end

   // mostly short gaps, a few long ones
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // expected arc length for one point pair under the current centre
   function automatic arc_result_type predict_arc(point_pair_type p);
      logic signed [31:0] av [3];
      logic signed [31:0] bv [3];
      logic signed [32:0] da, db;
      logic [32:0]  ma, mb;
      logic [127:0] rsq, pos, neg, dmag, rem, prod;
      logic [63:0]  cmag, s, q, cand, r, v;
      longint x, y, z, xs, ys, stp;
      logic cneg;
      arc_result_type res;
      av = '{p.ax, p.ay, p.az};
      bv = '{p.bx, p.by, p.bz};
      rsq = '0; pos = '0; neg = '0;
      for (int k = 0; k < 3; k++) begin
         da = $signed({av[k][31], av[k]}) - $signed({centre[k][31], centre[k]});
         db = $signed({bv[k][31], bv[k]}) - $signed({centre[k][31], centre[k]});
         ma = da[32] ? 33'(-da) : 33'(da);
         mb = db[32] ? 33'(-db) : 33'(db);
         rsq += 128'(ma) * 128'(ma);
         if (da[32] != db[32]) neg += 128'(ma) * 128'(mb);
         else pos += 128'(ma) * 128'(mb);
      end
      if (rsq == 0) begin
         res.arc = '0;
         res.zero = 1'b1;
         return res;
      end
      cneg = (pos < neg);
      dmag = cneg ? neg - pos : pos - neg;
      // cosine magnitude, clamped at one
      if (dmag >= rsq) cmag = 64'd1 << ANG_BITS;
      else begin
         rem = dmag;
         q = 0;
         for (int i = 0; i < ANG_BITS; i++) begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= rsq) begin
               rem = rem - rsq;
               q[0] = 1'b1;
            end
         end
         cmag = q;
      end
      // sine from the cosine
      v = (64'd1 << (2 * ANG_BITS)) - cmag * cmag;
      s = 0;
      for (int b = 30; b >= 0; b--) begin
         cand = s | (64'd1 << b);
         if (cand * cand <= v) s = cand;
      end
      // CORDIC vectoring for the angle
      x = longint'(cmag);
      y = longint'(s);
      z = 0;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         stp = (i < 10) ? ATAN_Q30[i] : (64'sd1 <<< (ANG_BITS - i));
         if (y > 0) begin
            x = x + ys; y = y - xs; z += stp;
         end else if (y < 0) begin
            x = x - ys; y = y + xs; z -= stp;
         end
      end
      if (cneg) z = longint'(PI_Q30) - z;
      if (z < 0) z = 0;
      if (z > longint'(PI_Q30)) z = longint'(PI_Q30);
      // radius
      r = 0;
      for (int b = 33; b >= 0; b--) begin
         cand = r | (64'd1 << b);
         if (128'(cand) * 128'(cand) <= rsq) r = cand;
      end
      prod = 128'(r) * 128'(z) + (128'd1 << (ANG_BITS - 1));
      if ((prod >> ANG_BITS) > 128'hFFFF_FFFF) res.arc = 32'hFFFF_FFFF;
      else res.arc = prod[ANG_BITS +: 32];
      res.zero = 1'b0;
      return res;
   endfunction

   // APB write of one centre register, indexes past the last register are ignored by the block
   task automatic write_centre(int idx, logic [31:0] value);
      @(negedge clock);
      psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
      paddr = 4'(idx * 4); pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (idx < REG_COUNT) centre[idx] = value;
      @(negedge clock);
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
   endtask

   task automatic set_centre(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz);
      write_centre(REG_CENTER_X, cx);
      write_centre(REG_CENTER_Y, cy);
      write_centre(REG_CENTER_Z, cz);
   endtask

   // stop offering, wait until every result is in and the pipeline has emptied
   task automatic drain();
      @(negedge clock);
      req.valid = 1'b0;
      while (pending_arcs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // offer one item, hold it until accepted, then maybe idle
   task automatic send_pair(point_pair_type p);
      int g;
      @(negedge clock);
      req.valid = 1'b1;
      req.point_a_x = p.ax; req.point_a_y = p.ay; req.point_a_z = p.az;
      req.point_b_x = p.bx; req.point_b_y = p.by; req.point_b_z = p.bz;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      pending_arcs.push_back(predict_arc(p));
      g = gap_len();
      if (g > 0) begin
         @(negedge clock);
         req.valid = 1'b0;
         repeat (g - 1) @(negedge clock);
      end
   endtask

   // result ready: random stalls, plus a long hold when asked
   initial begin
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left = 0;
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_active = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp.ready = 1'b0;
            hold_left--;
            if (hold_left == 0) hold_active = 1'b0;
         end else if (stall_left > 0) begin
            rsp.ready = 1'b0;
            stall_left--;
         end else begin
            rsp.ready = 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left = gap_len();
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      arc_result_type exp_r;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_arcs.size() == 0) begin
            $display("%0t: unexpected item arc=%h zero=%b", $time, rsp.arc_length,
                     rsp.zero_radius);
            error_count++;
         end else begin
            exp_r = pending_arcs.pop_front();
            if (rsp.arc_length !== exp_r.arc) begin
               $display("%0t: arc_length expected %h actual %h", $time, exp_r.arc,
                        rsp.arc_length);
               error_count++;
            end
            if (rsp.zero_radius !== exp_r.zero) begin
               $display("%0t: zero_radius expected %b actual %b", $time, exp_r.zero,
                        rsp.zero_radius);
               error_count++;
            end
         end
      end
   end

   function automatic point_pair_type make_pair(logic [31:0] ax, logic [31:0] ay,
      logic [31:0] az, logic [31:0] bx, logic [31:0] by, logic [31:0] bz);
      point_pair_type p;
      p.ax = ax; p.ay = ay; p.az = az; p.bx = bx; p.by = by; p.bz = bz;
      return p;
   endfunction

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 4))
         0: return $urandom();
         1: return 32'($signed($urandom_range(0, 2 * 65536 * 64)) - 65536 * 64);
         2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'($signed($urandom_range(0, 2 * 65536 * 4096)) - 65536 * 4096);
      endcase
   endfunction

   // b mostly on the same sphere: coordinates of a about the centre, permuted and sign-flipped
   function automatic point_pair_type rand_pair();
      point_pair_type p;
      logic signed [32:0] d [3];
      logic signed [32:0] e [3];
      logic signed [32:0] t;
      int sel;
      p.ax = rand_coord(); p.ay = rand_coord(); p.az = rand_coord();
      sel = $urandom_range(0, 9);
      if (sel < 6) begin
         d[0] = $signed({p.ax[31], p.ax}) - centre[0];
         d[1] = $signed({p.ay[31], p.ay}) - centre[1];
         d[2] = $signed({p.az[31], p.az}) - centre[2];
         for (int k = 0; k < 3; k++) begin
            e[k] = d[(k + sel) % 3];
            if ($urandom_range(0, 1)) e[k] = -e[k];
         end
         t = e[0] + centre[0]; p.bx = t[31:0];
         t = e[1] + centre[1]; p.by = t[31:0];
         t = e[2] + centre[2]; p.bz = t[31:0];
      end else if (sel < 8) begin
         p.bx = rand_coord(); p.by = rand_coord(); p.bz = rand_coord();
      end else if (sel == 8) begin
         // nearly the same point
         p.bx = p.ax + 32'($urandom_range(0, 15)) - 8;
         p.by = p.ay + 32'($urandom_range(0, 15)) - 8;
         p.bz = p.az;
      end else begin
         // a on the centre
         p.ax = centre[0]; p.ay = centre[1]; p.az = centre[2];
         p.bx = rand_coord(); p.by = rand_coord(); p.bz = rand_coord();
      end
      return p;
   endfunction

   task automatic send_random(int count);
      for (int n = 0; n < count; n++) send_pair(rand_pair());
   endtask

   // extremes, special cases and opposite points
   task automatic test_directed();
      localparam logic [31:0] ONE = 32'h0001_0000;
      localparam logic [31:0] MONE = 32'hFFFF_0000;
      localparam logic [31:0] MAXV = 32'h7FFF_FFFF;
      localparam logic [31:0] MINV = 32'h8000_0000;
      set_centre(0, 0, 0);
      send_pair(make_pair(0, 0, 0, ONE, ONE, ONE));
      send_pair(make_pair(ONE, 0, 0, ONE, 0, 0));
      send_pair(make_pair(ONE, 0, 0, MONE, 0, 0));
      send_pair(make_pair(ONE, 0, 0, 0, ONE, 0));
      send_pair(make_pair(ONE, 0, 0, 32'h0010_0000, 0, 0));
      send_pair(make_pair(ONE, 0, 0, 32'hFFF0_0000, 0, 0));
      send_pair(make_pair(MAXV, MAXV, MAXV, MINV, MINV, MINV));
      send_pair(make_pair(MINV, MINV, MINV, MAXV, MAXV, MAXV));
      send_pair(make_pair(MAXV, MINV, MAXV, MINV, MAXV, MINV));
      send_pair(make_pair(MAXV, 0, 0, 0, MAXV, 0));
      send_pair(make_pair(32'd1, 0, 0, 32'hFFFF_FFFF, 0, 0));
      send_pair(make_pair(32'd1, 0, 0, 0, 0, 32'd1));
      send_pair(make_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, MAXV, 0, MINV));
      drain();
      set_centre(MINV, MINV, MINV);
      send_pair(make_pair(MAXV, MAXV, MAXV, MINV, MINV, MINV));
      send_pair(make_pair(MINV, MINV, MINV, MAXV, MAXV, MAXV));
      send_pair(make_pair(MAXV, MINV, MINV, MINV, MAXV, MINV));
      send_pair(make_pair(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV));
      drain();
      set_centre(MAXV, MINV, ONE);
      send_pair(make_pair(MAXV, MINV, ONE, 0, 0, 0));
      send_pair(make_pair(MINV, MAXV, MONE, MAXV, MINV, ONE));
      send_pair(make_pair(MINV, MINV, ONE, MINV, MINV, ONE));
      drain();
   endtask

   // several centre settings, extremes among them, and an out-of-range index
   task automatic test_centre_settings();
      set_centre(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_random(60);
      drain();
      set_centre(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      send_random(60);
      drain();
      write_centre(REG_COUNT, $urandom());
      set_centre($urandom(), $urandom(), $urandom());
      send_random(60);
      drain();
   endtask

   // long random run across a few centres
   task automatic test_random_stream();
      for (int ph = 0; ph < 6; ph++) begin
         if (ph == 0) set_centre(0, 0, 0);
         else set_centre(rand_coord(), rand_coord(), rand_coord());
         send_random(225);
         drain();
      end
   endtask

   // receiver holds off while the sender keeps offering
   task automatic test_back_pressure();
      set_centre(rand_coord(), rand_coord(), rand_coord());
      no_idle = 1'b1;
      hold_request = 1'b1;
      send_random(300);
      @(negedge clock);
      req.valid = 1'b0;
      no_idle = 1'b0;
      wait (!hold_request && !hold_active);
      drain();
   endtask

   // back-to-back items with no idling on either side
   task automatic test_full_rate();
      no_idle = 1'b1;
      send_random(100);
      @(negedge clock);
      req.valid = 1'b0;
      no_idle = 1'b0;
      drain();
   endtask

   initial begin
      error_count = 0;
      no_idle = 1'b0;
      hold_request = 1'b0;
      hold_active = 1'b0;
      centre = '{0, 0, 0};
      reset = 1'b1;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      req.valid = 1'b0;
      req.point_a_x = '0; req.point_a_y = '0; req.point_a_z = '0;
      req.point_b_x = '0; req.point_b_y = '0; req.point_b_z = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_centre_settings();
      test_random_stream();
      test_back_pressure();
      test_full_rate();

      @(negedge clock);
      req.valid = 1'b0;
      drain();
      if (error_count == 0 && pending_arcs.size() == 0) begin
         $display("great_circle_arc_length verification clean");
      end else begin
         $display("great_circle_arc_length verification failed");
      end
      $finish;
   end

endmodule
